### sv/swsalu_pkg.sv
// ----------------------------------------------------------------------------
// swsalu_pkg
// Shared types, op codes and helpers for the signed wrap/saturate ALU.
// ----------------------------------------------------------------------------
package swsalu_pkg;

	// operand and result width in bits (2 to 64)
	localparam int unsigned WIDTH = 32;
	// fixed widths of the stream fields
	localparam int unsigned FIELD_W = 32;
	localparam int unsigned WIDE_W  = 64;
	localparam int unsigned OP_W    = 4;

	localparam logic [WIDTH-1:0] W_MAX = {1'b0, {(WIDTH-1){1'b1}}};
	localparam logic [WIDTH-1:0] W_MIN = {1'b1, {(WIDTH-1){1'b0}}};
	localparam logic [WIDTH-1:0] W_ONE = WIDTH'(1);
	localparam logic [WIDTH-1:0] W_ZERO = '0;

	typedef enum logic [OP_W-1:0] {
		OP_WADD    = 4'd0,
		OP_WSUB    = 4'd1,
		OP_WMUL    = 4'd2,
		OP_SADD    = 4'd3,
		OP_SSUB    = 4'd4,
		OP_SMUL    = 4'd5,
		OP_LT      = 4'd6,
		OP_EQ      = 4'd7,
		OP_SNARROW = 4'd8,
		OP_WNARROW = 4'd9
	} alu_op_t;

	// decoded word after operand reduction
	typedef struct packed {
		alu_op_t            op;
		logic [WIDTH-1:0]   lhs;
		logic [WIDTH-1:0]   rhs;
		logic [WIDE_W-1:0]  wide_value;
	} dec_t;

	// raw arithmetic results ahead of clamping and selection
	typedef struct packed {
		alu_op_t              op;
		logic [WIDTH:0]       sum;
		logic [WIDTH:0]       diff;
		logic [2*WIDTH-1:0]   prod;
		logic                 lt;
		logic                 eq;
		logic [WIDTH-1:0]     wide_lo;
		logic                 nar_over;
		logic                 nar_under;
	} exe_t;

	// sign-extend a 32-bit field and keep the low WIDTH bits
	function automatic logic [WIDTH-1:0] reduce_field(input logic [FIELD_W-1:0] x);
		logic [WIDE_W-1:0] e;
		e = WIDE_W'($signed(x));
		return e[WIDTH-1:0];
	endfunction

	// sign-extend a WIDTH-bit result and keep the low 32 bits
	function automatic logic [FIELD_W-1:0] to_field(input logic [WIDTH-1:0] r);
		logic [WIDE_W-1:0] e;
		e = WIDE_W'($signed(r));
		return e[FIELD_W-1:0];
	endfunction

endpackage

### sv/swsalu_decode.sv
// ----------------------------------------------------------------------------
// swsalu_decode
// Stage 1: takes the op and operands and reduces them to WIDTH bits.
// ----------------------------------------------------------------------------
module swsalu_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [swsalu_pkg::OP_W-1:0]   op,
	input  logic [swsalu_pkg::FIELD_W-1:0] lhs,
	input  logic [swsalu_pkg::FIELD_W-1:0] rhs,
	input  logic [swsalu_pkg::WIDE_W-1:0] wide_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output swsalu_pkg::dec_t              out_data
);

	logic             v_s1;
	swsalu_pkg::dec_t d_s1;

	// stage takes a word when empty or when its word moves on
	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;
	assign out_data  = d_s1;

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// operand reduction
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s1.op         <= swsalu_pkg::alu_op_t'(op);
			d_s1.lhs        <= swsalu_pkg::reduce_field(lhs);
			d_s1.rhs        <= swsalu_pkg::reduce_field(rhs);
			d_s1.wide_value <= wide_value;
		end
	end

endmodule

### sv/swsalu_exec.sv
// ----------------------------------------------------------------------------
// swsalu_exec
// Stage 2: exact sum, difference and product, compares and narrowing range
// checks.
// ----------------------------------------------------------------------------
module swsalu_exec (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  swsalu_pkg::dec_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output swsalu_pkg::exe_t out_data
);

	localparam int unsigned W  = swsalu_pkg::WIDTH;
	localparam int unsigned WW = swsalu_pkg::WIDE_W;

	logic                 v_s2;
	swsalu_pkg::exe_t     e_s2;
	logic signed [2*W-1:0] prod;
	logic [WW-W:0]        wide_top;

	assign in_ready  = !v_s2 || out_ready;
	assign out_valid = v_s2;
	assign out_data  = e_s2;

	// signed WIDTH x WIDTH product, exact in 2*WIDTH bits
	assign prod     = $signed(in_data.lhs) * $signed(in_data.rhs);
	// bits that must all match the sign for the wide value to fit
	assign wide_top = in_data.wide_value[WW-1:W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	// arithmetic results
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			e_s2.op        <= in_data.op;
			e_s2.sum       <= {in_data.lhs[W-1], in_data.lhs} + {in_data.rhs[W-1], in_data.rhs};
			e_s2.diff      <= {in_data.lhs[W-1], in_data.lhs} - {in_data.rhs[W-1], in_data.rhs};
			e_s2.prod      <= prod;
			e_s2.lt        <= $signed(in_data.lhs) < $signed(in_data.rhs);
			e_s2.eq        <= in_data.lhs == in_data.rhs;
			e_s2.wide_lo   <= in_data.wide_value[W-1:0];
			e_s2.nar_over  <= !in_data.wide_value[WW-1] && (|wide_top);
			e_s2.nar_under <= in_data.wide_value[WW-1] && !(&wide_top);
		end
	end

endmodule

### sv/swsalu_resolve.sv
// ----------------------------------------------------------------------------
// swsalu_resolve
// Stage 3: clamps saturating ops, selects the result by op and holds the
// output word.
// ----------------------------------------------------------------------------
module swsalu_resolve (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  swsalu_pkg::exe_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [swsalu_pkg::FIELD_W-1:0] result
);

	localparam int unsigned W = swsalu_pkg::WIDTH;

	logic                            v_s3;
	logic [swsalu_pkg::FIELD_W-1:0]  r_s3;
	swsalu_pkg::alu_op_t             op_s3;
	logic [W-1:0]                    r_next;
	logic                            add_ovf;
	logic                            sub_ovf;
	logic                            mul_fit;
	logic [W:0]                      prod_top;

	assign in_ready  = !v_s3 || out_ready;
	assign out_valid = v_s3;
	assign result    = r_s3;

	// overflow tests on the exact results
	assign add_ovf  = in_data.sum[W] ^ in_data.sum[W-1];
	assign sub_ovf  = in_data.diff[W] ^ in_data.diff[W-1];
	assign prod_top = in_data.prod[2*W-1:W-1];
	assign mul_fit  = (&prod_top) || !(|prod_top);

	// result select
	always_comb begin
		case (in_data.op)
			swsalu_pkg::OP_WADD: begin
				r_next = in_data.sum[W-1:0];
			end
			swsalu_pkg::OP_WSUB: begin
				r_next = in_data.diff[W-1:0];
			end
			swsalu_pkg::OP_WMUL: begin
				r_next = in_data.prod[W-1:0];
			end
			swsalu_pkg::OP_SADD: begin
				if (add_ovf) begin
					r_next = in_data.sum[W] ? swsalu_pkg::W_MIN : swsalu_pkg::W_MAX;
				end else begin
					r_next = in_data.sum[W-1:0];
				end
			end
			swsalu_pkg::OP_SSUB: begin
				if (sub_ovf) begin
					r_next = in_data.diff[W] ? swsalu_pkg::W_MIN : swsalu_pkg::W_MAX;
				end else begin
					r_next = in_data.diff[W-1:0];
				end
			end
			swsalu_pkg::OP_SMUL: begin
				if (!mul_fit) begin
					r_next = in_data.prod[2*W-1] ? swsalu_pkg::W_MIN : swsalu_pkg::W_MAX;
				end else begin
					r_next = in_data.prod[W-1:0];
				end
			end
			swsalu_pkg::OP_LT: begin
				r_next = in_data.lt ? swsalu_pkg::W_ONE : swsalu_pkg::W_ZERO;
			end
			swsalu_pkg::OP_EQ: begin
				r_next = in_data.eq ? swsalu_pkg::W_ONE : swsalu_pkg::W_ZERO;
			end
			swsalu_pkg::OP_SNARROW: begin
				if (in_data.nar_over) begin
					r_next = swsalu_pkg::W_MAX;
				end else if (in_data.nar_under) begin
					r_next = swsalu_pkg::W_MIN;
				end else begin
					r_next = in_data.wide_lo;
				end
			end
			swsalu_pkg::OP_WNARROW: begin
				r_next = in_data.wide_lo;
			end
			default: begin
				r_next = swsalu_pkg::W_ZERO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			r_s3  <= swsalu_pkg::to_field(r_next);
			op_s3 <= in_data.op;
		end
	end

	// compare ops give only zero or one
	a_cmp_bool: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && (op_s3 == swsalu_pkg::OP_LT || op_s3 == swsalu_pkg::OP_EQ))
		|-> (r_s3[swsalu_pkg::FIELD_W-1:1] == '0))
		else $error("compare result not 0 or 1");

	// an empty output stage never blocks the stage before it
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s3 |-> in_ready)
		else $error("empty output stage not ready");

	// a word taken in shows up at the output on the next cycle
	a_take_show: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s3)
		else $error("accepted word lost in output stage");

endmodule

### sv/signed_wrap_saturate_alu.sv
// ----------------------------------------------------------------------------
// signed_wrap_saturate_alu
// Signed two's-complement ALU with wrapping and saturating ops, compares
// and 64-bit narrowing.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per word: tuser holds the op code, tdata the
//   operands. m_axis returns one 32-bit result word per operation, in order.
//   Op codes outside the defined set return zero.
// Pipeline:
//   three register stages (operand reduction, add/sub/multiply and compares,
//   clamp and select). A word accepted on s_axis passes through these
//   registers in that order before it shows on m_axis_tvalid. Throughput is
//   one word per cycle while m_axis_tready stays high; the signed
//   multiplier in the middle stage sets the clock limit.
// Flow control:
//   each stage holds its word until the next stage frees up, so bubbles are
//   squeezed out and s_axis_tready stays high while any stage has room. When
//   the receiver holds m_axis_tready low the pipe fills and then stalls; no
//   word is dropped or repeated.
// Reset:
//   arst_n clears every valid bit at once; the pipe comes up empty and ready.
// ----------------------------------------------------------------------------
module signed_wrap_saturate_alu (
	input  logic         clk,
	input  logic         arst_n,
	// input words
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // lhs[31:0], rhs[63:32], wide_value[127:64]
	input  logic [3:0]   s_axis_tuser,  // op[3:0]
	// result words
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [31:0]  m_axis_tdata   // result[31:0]
);

	logic             dec_valid;
	logic             dec_ready;
	swsalu_pkg::dec_t dec_data;
	logic             exe_valid;
	logic             exe_ready;
	swsalu_pkg::exe_t exe_data;

	// stage 1: operand reduction
	swsalu_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.op         (s_axis_tuser),
		.lhs        (s_axis_tdata[31:0]),
		.rhs        (s_axis_tdata[63:32]),
		.wide_value (s_axis_tdata[127:64]),
		.out_valid  (dec_valid),
		.out_ready  (dec_ready),
		.out_data   (dec_data)
	);

	// stage 2: arithmetic
	swsalu_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_data   (dec_data),
		.out_valid (exe_valid),
		.out_ready (exe_ready),
		.out_data  (exe_data)
	);

	// stage 3: clamp, select and output register
	swsalu_resolve u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (exe_valid),
		.in_ready  (exe_ready),
		.in_data   (exe_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.result    (m_axis_tdata)
	);

endmodule
